FILE: rtl/dh_forward_kinematics_chain_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DH forward kinematics chain
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DH_FORWARD_KINEMATICS_CHAIN_TOP_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DHFK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DHFK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DHFK_ASSERT(lbl, prop, msg)
`define DHFK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Types, constants and fixed-point helpers shared by the DH chain modules.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int unsigned CorSteps = 30;
    localparam int unsigned FifoDepth = 2;

    typedef logic signed [35:0] t_cw;

    localparam t_cw COR_GAIN = 36'sd652032874;
    localparam t_cw ONE_Q30 = 36'sd1073741824;
    localparam logic signed [40:0] POS_MAX = 41'sd262143;
    localparam logic signed [40:0] POS_MIN = -41'sd262144;

    typedef struct packed {
        logic [31:0]        theta;
        logic [31:0]        alpha;
        logic signed [15:0] d;
        logic signed [15:0] a;
        logic               last;
    } t_job;

    typedef struct packed {
        logic start;
        logic vec;
        t_cw  x;
        t_cw  y;
        t_cw  z;
    } t_cor_req;

    typedef struct packed {
        logic done;
        t_cw  x;
        t_cw  y;
        t_cw  z;
    } t_cor_rsp;

    typedef struct packed {
        logic [4:0]         frame_index;
        logic signed [18:0] origin_x;
        logic signed [18:0] origin_y;
        logic signed [18:0] origin_z;
        logic signed [18:0] shifted_x;
        logic signed [18:0] shifted_y;
        logic signed [18:0] shifted_z;
        logic signed [14:0] pitch;
        logic               chain_end;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_T,
        ST_WAIT_T,
        ST_LOAD_A,
        ST_WAIT_A,
        ST_DH,
        ST_MAT,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_VLOAD,
        ST_VWAIT,
        ST_DEG,
        ST_DONE
    } t_state;

    // Arctangent of 2^-i as a binary angle (2^32 per turn).
    function automatic t_cw atan_bam(input logic [4:0] idx);
        t_cw v;
        case (idx)
            5'd0:  v = 36'h020000000;
            5'd1:  v = 36'h012E4051D;
            5'd2:  v = 36'h009FB385B;
            5'd3:  v = 36'h0051111D4;
            5'd4:  v = 36'h0028B0D43;
            5'd5:  v = 36'h00145D7E1;
            5'd6:  v = 36'h000A2F61E;
            5'd7:  v = 36'h000517C55;
            5'd8:  v = 36'h00028BE53;
            5'd9:  v = 36'h000145F2F;
            5'd10: v = 36'h0000A2F98;
            5'd11: v = 36'h0000517CC;
            5'd12: v = 36'h000028BE6;
            5'd13: v = 36'h0000145F3;
            5'd14: v = 36'h00000A2FA;
            5'd15: v = 36'h00000517D;
            5'd16: v = 36'h0000028BE;
            5'd17: v = 36'h00000145F;
            5'd18: v = 36'h000000A30;
            5'd19: v = 36'h000000518;
            5'd20: v = 36'h00000028C;
            5'd21: v = 36'h000000146;
            5'd22: v = 36'h0000000A3;
            5'd23: v = 36'h000000051;
            5'd24: v = 36'h000000029;
            5'd25: v = 36'h000000014;
            5'd26: v = 36'h00000000A;
            5'd27: v = 36'h000000005;
            5'd28: v = 36'h000000003;
            5'd29: v = 36'h000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a Q30 product sum once: add half, floor shift by 30.
    function automatic logic signed [39:0] rnd30(input logic signed [69:0] v);
        logic signed [69:0] t;
        t = v + 70'sd536870912;
        return t[69:30];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [18:0] sat_pos(input logic signed [40:0] v);
        logic signed [40:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX;
        end else if (v < POS_MIN) begin
            r = POS_MIN;
        end else begin
            r = v;
        end
        return r[18:0];
    endfunction

    // Clamp a CORDIC output to the unit range and undo the half-turn fold.
    function automatic logic signed [31:0] sat_unit(input t_cw v, input logic flip);
        t_cw c;
        t_cw r;
        if (v > ONE_Q30) begin
            c = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            c = -ONE_Q30;
        end else begin
            c = v;
        end
        r = flip ? -c : c;
        return r[31:0];
    endfunction

endpackage

FILE: rtl/dh_forward_kinematics_chain_top.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_top
// Denavit-Hartenberg forward kinematics chain, one joint word per item.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word per joint (angle, theta offset, d, a, twist),
// tlast marks the final joint of the chain. Output stream m_axis: one word
// per joint with the frame number, the frame origin, the origin shifted along
// the z axis (frames 3 and 5), and on the closing word the end pitch; tlast
// marks the closing word. The APB port holds the two z axis offsets.
// Each joint runs through one shared CORDIC and one shared multiplier; a
// closing joint adds the square root and a vectoring CORDIC pass. The
// engine works on one joint at a time, so it does not start a new joint
// before it is through with the last one; a two-word queue in front of it
// lets the next joints be accepted meanwhile.
// Synchronous reset empties the queue, clears the joint count, restores the
// identity chain and loads the default offsets. When m_axis_tready is low
// the result waits in the output register, the engine finishes the next
// joint and then holds, and the queue fills before s_axis_tready drops.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain_top import dhfk_pkg::*; #(
    parameter int MAX_JOINTS = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint_angle, theta_offset, link_offset_d, link_length_a, link_twist
    input  logic [79:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_index, origin_x, origin_y, origin_z, shifted_x, shifted_y,
    // shifted_z, pitch, zero fill
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0] r_third_off;
    logic [15:0] r_fifth_off;
    logic        w_push_valid;
    logic        w_push_ready;
    t_job        w_push_job;
    logic        w_pop_valid;
    logic        w_pop;
    t_job        w_pop_job;
    t_result     w_res;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, r_fifth_off} : {16'd0, r_third_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_third_off <= 16'd768;
            r_fifth_off <= 16'd2496;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_fifth_off <= pwdata[15:0];
            end else begin
                r_third_off <= pwdata[15:0];
            end
        end
    end

    dhfk_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_joint_angle   (s_axis_tdata[15:0]),
        .i_theta_offset  (s_axis_tdata[31:16]),
        .i_link_offset_d (s_axis_tdata[47:32]),
        .i_link_length_a (s_axis_tdata[63:48]),
        .i_link_twist    (s_axis_tdata[79:64]),
        .i_last_joint    (s_axis_tlast),
        .o_push_valid    (w_push_valid),
        .i_push_ready    (w_push_ready),
        .o_push_job      (w_push_job)
    );

    dhfk_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_job    (w_pop_job)
    );

    dhfk_core #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .i_job       (w_pop_job),
        .o_job_pop   (w_pop),
        .i_third_off (r_third_off),
        .i_fifth_off (r_fifth_off),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_res)
    );

    assign m_axis_tdata = {2'b00, w_res.pitch, w_res.shifted_z, w_res.shifted_y,
                           w_res.shifted_x, w_res.origin_z, w_res.origin_y,
                           w_res.origin_x, w_res.frame_index};
    assign m_axis_tlast = w_res.chain_end;

endmodule

FILE: rtl/dhfk_front.sv
// ----------------------------------------------------------------------------
// dhfk_front
// Accepts joint words and turns both angles into 32 bit binary angles.
// ----------------------------------------------------------------------------
module dhfk_front import dhfk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_joint_angle,
    input  logic signed [15:0] i_theta_offset,
    input  logic signed [15:0] i_link_offset_d,
    input  logic signed [15:0] i_link_length_a,
    input  logic signed [15:0] i_link_twist,
    input  logic               i_last_joint,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output t_job               o_push_job
);

    logic               r_v;
    logic signed [15:0] r_jang;
    logic signed [15:0] r_toff;
    logic signed [15:0] r_d;
    logic signed [15:0] r_a;
    logic signed [15:0] r_tw;
    logic               r_last;
    logic signed [33:0] w_pj;
    logic signed [33:0] w_pt;
    logic signed [33:0] w_pa;

    assign o_ready = !r_v || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_v    <= 1'b1;
            r_jang <= i_joint_angle;
            r_toff <= i_theta_offset;
            r_d    <= i_link_offset_d;
            r_a    <= i_link_length_a;
            r_tw   <= i_link_twist;
            r_last <= i_last_joint;
        end else if (i_push_ready) begin
            r_v <= 1'b0;
        end
    end

    // Hundredths of a degree and Q3.13 radians both scale to a full 2^32 turn.
    assign w_pj = r_jang * 18'sd119305;
    assign w_pt = r_toff * 18'sd83443;
    assign w_pa = r_tw * 18'sd83443;

    assign o_push_valid     = r_v;
    assign o_push_job.theta = w_pj[31:0] + w_pt[31:0];
    assign o_push_job.alpha = w_pa[31:0];
    assign o_push_job.d     = r_d;
    assign o_push_job.a     = r_a;
    assign o_push_job.last  = r_last;

endmodule

FILE: rtl/dhfk_fifo.sv
// ----------------------------------------------------------------------------
// dhfk_fifo
// Two-entry queue between the angle front end and the transform engine.
// ----------------------------------------------------------------------------
module dhfk_fifo import dhfk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_job o_pop_job
);

    t_job                          r_mem [FifoDepth];
    logic [$clog2(FifoDepth)-1:0]  r_wp;
    logic [$clog2(FifoDepth)-1:0]  r_rp;
    logic [$clog2(FifoDepth):0]    r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign o_push_ready = (r_cnt != ($clog2(FifoDepth) + 1)'(FifoDepth));
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_job    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/dhfk_cordic.sv
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module dhfk_cordic import dhfk_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cor_req i_req,
    output t_cor_rsp o_rsp
);

    logic       r_busy;
    logic       r_done;
    logic       r_vec;
    logic [4:0] r_i;
    t_cw        r_x;
    t_cw        r_y;
    t_cw        r_z;
    t_cw        w_dx;
    t_cw        w_dy;
    t_cw        w_ang;
    logic       w_neg;

    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_ang = atan_bam(r_i);
    // Rotation drives z toward zero, vectoring drives y toward zero.
    assign w_neg = r_vec ? r_y[35] : !r_z[35];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_vec  <= i_req.vec;
                r_i    <= '0;
                r_x    <= i_req.x;
                r_y    <= i_req.y;
                r_z    <= i_req.z;
            end else if (r_busy) begin
                if (w_neg) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_ang;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_ang;
                end
                r_i <= r_i + 1'b1;
                if (r_i == 5'(CorSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;
    assign o_rsp.z    = r_z;

endmodule

FILE: rtl/dhfk_core.sv
// ----------------------------------------------------------------------------
// dhfk_core
// Transform engine: sine/cosine, DH matrix, chain product, shifted points
// and end pitch on one shared multiplier and one shared CORDIC.
// ----------------------------------------------------------------------------
`include "dh_forward_kinematics_chain_top_assert.svh"
module dhfk_core import dhfk_pkg::*; #(
    parameter int MAX_JOINTS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_pop,
    input  logic [15:0] i_third_off,
    input  logic [15:0] i_fifth_off,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    t_state              r_state;
    t_state              n_state;
    t_cor_req            w_req;
    t_cor_rsp            w_rsp;

    logic [31:0]         r_theta;
    logic [31:0]         r_alpha;
    logic signed [15:0]  r_d;
    logic signed [15:0]  r_a;
    logic                r_last;
    logic                r_flip;
    logic signed [31:0]  r_ct;
    logic signed [31:0]  r_st;
    logic signed [31:0]  r_ca;
    logic signed [31:0]  r_sa;
    logic signed [31:0]  r_dh [9];
    logic signed [31:0]  r_e [3];
    logic signed [31:0]  r_chain [12];
    logic signed [31:0]  r_nt [12];
    logic signed [18:0]  r_sh [3];
    logic [4:0]          r_cnt;
    logic                r_ph;
    logic [1:0]          r_row;
    logic [1:0]          r_col;
    logic [1:0]          r_k;
    logic signed [67:0]  r_prod;
    logic signed [69:0]  r_acc;
    logic [63:0]         r_sv;
    logic [63:0]         r_sr;
    logic signed [33:0]  r_z;
    logic signed [14:0]  r_pitch;
    logic [3:0]          r_jcnt;
    logic                r_ovalid;
    t_result             r_out;

    logic [31:0]         w_ang;
    logic                w_flip;
    logic [31:0]         w_angf;
    logic signed [33:0]  w_ma;
    logic signed [33:0]  w_mb;
    logic signed [69:0]  w_sum;
    logic signed [39:0]  w_rnd;
    logic [3:0]          w_ci;
    logic [3:0]          w_di;
    logic [3:0]          w_ni;
    logic [3:0]          w_ti;
    logic [3:0]          w_si;
    logic [4:0]          w_frame;
    logic                w_end;
    logic [15:0]         w_off;
    logic                w_free;
    logic                w_degen;
    logic [63:0]         w_bit;
    logic [63:0]         w_trial;
    logic signed [67:0]  w_deg;
    logic signed [35:0]  w_degq;

    dhfk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_frame = {1'b0, r_jcnt} + 5'd1;
    assign w_end   = r_last || (w_frame >= 5'(MAX_JOINTS));
    assign w_off   = (w_frame == 5'd3) ? i_third_off :
                     (w_frame == 5'd5) ? i_fifth_off : 16'd0;
    assign w_free  = !r_ovalid || i_ready;
    assign w_degen = (r_sr == 64'd0) && (r_nt[6] == 32'sd0);

    // Fold the angle into the half turn around zero before rotating.
    assign w_ang  = (r_state == ST_LOAD_T) ? r_theta : r_alpha;
    assign w_flip = (w_ang + 32'h4000_0000) >= 32'h8000_0000;
    assign w_angf = w_flip ? (w_ang + 32'h8000_0000) : w_ang;

    assign w_ci = 4'({r_row, 1'b0}) + 4'(r_row) + 4'(r_k);
    assign w_di = 4'({r_k, 1'b0}) + 4'(r_k) + 4'(r_col);
    assign w_ni = 4'({r_row, 1'b0}) + 4'(r_row) + 4'(r_col);
    assign w_ti = 4'd9 + 4'(r_row);
    assign w_si = 4'({r_cnt[1:0], 1'b0}) + 4'(r_cnt[1:0]);

    assign w_sum = r_acc + 70'(r_prod);
    assign w_rnd = rnd30(w_sum);

    assign w_bit   = 64'd1 << (7'd62 - 7'({r_cnt, 1'b0}));
    assign w_trial = r_sr + w_bit;

    assign w_deg  = r_prod + 68'sd2147483648;
    assign w_degq = w_deg[67:32];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_job_valid) n_state = ST_LOAD_T;
            ST_LOAD_T: n_state = ST_WAIT_T;
            ST_WAIT_T: if (w_rsp.done) n_state = ST_LOAD_A;
            ST_LOAD_A: n_state = ST_WAIT_A;
            ST_WAIT_A: if (w_rsp.done) n_state = ST_DH;
            ST_DH:     if (r_ph && r_cnt == 5'd5) n_state = ST_MAT;
            ST_MAT: begin
                if (r_ph && r_k == 2'd2 && r_row == 2'd2 && r_col == 2'd3) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_ph && r_cnt == 5'd2) begin
                    n_state = w_end ? ST_SQ : ST_DONE;
                end
            end
            ST_SQ:     if (r_ph && r_cnt == 5'd1) n_state = ST_SQRT;
            ST_SQRT:   if (r_cnt == 5'd31) n_state = ST_VLOAD;
            ST_VLOAD:  n_state = w_degen ? ST_DONE : ST_VWAIT;
            ST_VWAIT:  if (w_rsp.done) n_state = ST_DEG;
            ST_DEG:    if (r_ph) n_state = ST_DONE;
            ST_DONE:   if (w_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == ST_IDLE) && i_job_valid;
        w_req.start = (r_state == ST_LOAD_T) || (r_state == ST_LOAD_A) ||
                      ((r_state == ST_VLOAD) && !w_degen);
        w_req.vec = (r_state == ST_VLOAD);
        if (r_state == ST_VLOAD) begin
            w_req.x = {4'd0, r_sr[31:0]};
            w_req.y = -36'(r_nt[6]);
            w_req.z = '0;
        end else begin
            w_req.x = COR_GAIN;
            w_req.y = '0;
            w_req.z = 36'($signed(w_angf));
        end
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_DH: begin
                case (r_cnt)
                    5'd0: begin w_ma = 34'(r_st); w_mb = 34'(r_ca); end
                    5'd1: begin w_ma = 34'(r_st); w_mb = 34'(r_sa); end
                    5'd2: begin w_ma = 34'(r_ct); w_mb = 34'(r_ca); end
                    5'd3: begin w_ma = 34'(r_ct); w_mb = 34'(r_sa); end
                    5'd4: begin w_ma = 34'(r_a);  w_mb = 34'(r_ct); end
                    default: begin w_ma = 34'(r_a); w_mb = 34'(r_st); end
                endcase
            end
            ST_MAT: begin
                w_ma = 34'(r_chain[w_ci]);
                w_mb = (r_col == 2'd3) ? 34'(r_e[r_k]) : 34'(r_dh[w_di]);
            end
            ST_SHIFT: begin
                w_ma = 34'($signed({1'b0, w_off}));
                w_mb = 34'(r_nt[w_si + 4'd2]);
            end
            ST_SQ: begin
                w_ma = r_cnt[0] ? 34'(r_nt[3]) : 34'(r_nt[0]);
                w_mb = w_ma;
            end
            ST_DEG: begin
                w_ma = r_z;
                w_mb = 34'sd36000;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_jcnt   <= '0;
            for (int i = 0; i < 12; i++) begin
                r_chain[i] <= (i == 0 || i == 4 || i == 8) ? 32'sd1073741824 : 32'sd0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready && !(r_state == ST_DONE && w_free)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_theta <= i_job.theta;
                        r_alpha <= i_job.alpha;
                        r_d     <= i_job.d;
                        r_a     <= i_job.a;
                        r_last  <= i_job.last;
                        r_pitch <= '0;
                    end
                end
                ST_LOAD_T, ST_LOAD_A: begin
                    r_flip <= w_flip;
                end
                ST_WAIT_T: begin
                    if (w_rsp.done) begin
                        r_ct <= sat_unit(w_rsp.x, r_flip);
                        r_st <= sat_unit(w_rsp.y, r_flip);
                    end
                end
                ST_WAIT_A: begin
                    if (w_rsp.done) begin
                        r_ca  <= sat_unit(w_rsp.x, r_flip);
                        r_sa  <= sat_unit(w_rsp.y, r_flip);
                        r_cnt <= '0;
                        r_ph  <= 1'b0;
                        r_acc <= '0;
                    end
                end
                ST_DH: begin
                    r_dh[0] <= r_ct;
                    r_dh[3] <= r_st;
                    r_dh[6] <= '0;
                    r_dh[7] <= r_sa;
                    r_dh[8] <= r_ca;
                    r_e[2]  <= 32'(r_d);
                    if (!r_ph) begin
                        r_prod <= w_ma * w_mb;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph  <= 1'b0;
                        r_cnt <= r_cnt + 1'b1;
                        case (r_cnt)
                            5'd0: r_dh[1] <= -w_rnd[31:0];
                            5'd1: r_dh[2] <= w_rnd[31:0];
                            5'd2: r_dh[4] <= w_rnd[31:0];
                            5'd3: r_dh[5] <= -w_rnd[31:0];
                            5'd4: r_e[0]  <= w_rnd[31:0];
                            default: r_e[1] <= w_rnd[31:0];
                        endcase
                        if (r_cnt == 5'd5) begin
                            r_row <= '0;
                            r_col <= '0;
                            r_k   <= '0;
                        end
                    end
                end
                ST_MAT: begin
                    if (!r_ph) begin
                        r_prod <= w_ma * w_mb;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_k == 2'd2) begin
                            r_acc <= '0;
                            r_k   <= '0;
                            if (r_col == 2'd3) begin
                                r_nt[w_ti] <= 32'(sat_pos(41'(r_chain[w_ti]) + 41'(w_rnd)));
                                r_col      <= '0;
                                r_row      <= r_row + 1'b1;
                            end else begin
                                r_nt[w_ni] <= sat32(w_rnd);
                                r_col      <= r_col + 1'b1;
                            end
                            r_cnt <= '0;
                        end else begin
                            r_acc <= w_sum;
                            r_k   <= r_k + 1'b1;
                        end
                    end
                end
                ST_SHIFT: begin
                    if (!r_ph) begin
                        r_prod <= w_ma * w_mb;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        r_sh[r_cnt[1:0]] <= sat_pos(41'(r_nt[4'd9 + 4'(r_cnt[1:0])])
                                                    + 41'(w_rnd));
                        r_cnt <= (r_cnt == 5'd2) ? 5'd0 : r_cnt + 1'b1;
                    end
                end
                ST_SQ: begin
                    if (!r_ph) begin
                        r_prod <= w_ma * w_mb;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_cnt == 5'd0) begin
                            r_acc <= w_sum;
                            r_cnt <= 5'd1;
                        end else begin
                            r_sv  <= w_sum[63:0];
                            r_sr  <= '0;
                            r_acc <= '0;
                            r_cnt <= '0;
                        end
                    end
                end
                ST_SQRT: begin
                    // Restoring square root, two radicand bits per step.
                    if (r_sv >= w_trial) begin
                        r_sv <= r_sv - w_trial;
                        r_sr <= (r_sr >> 1) + w_bit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_VWAIT: begin
                    if (w_rsp.done) begin
                        r_z  <= w_rsp.z[33:0];
                        r_ph <= 1'b0;
                    end
                end
                ST_DEG: begin
                    if (!r_ph) begin
                        r_prod <= w_ma * w_mb;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (w_degq > 36'sd9000) begin
                            r_pitch <= 15'sd9000;
                        end else if (w_degq < -36'sd9000) begin
                            r_pitch <= -15'sd9000;
                        end else begin
                            r_pitch <= w_degq[14:0];
                        end
                    end
                end
                ST_DONE: begin
                    if (w_free) begin
                        r_ovalid          <= 1'b1;
                        r_out.frame_index <= w_frame;
                        r_out.origin_x    <= r_nt[9][18:0];
                        r_out.origin_y    <= r_nt[10][18:0];
                        r_out.origin_z    <= r_nt[11][18:0];
                        r_out.shifted_x   <= r_sh[0];
                        r_out.shifted_y   <= r_sh[1];
                        r_out.shifted_z   <= r_sh[2];
                        r_out.pitch       <= r_pitch;
                        r_out.chain_end   <= w_end;
                        if (w_end) begin
                            r_jcnt <= '0;
                            for (int i = 0; i < 12; i++) begin
                                r_chain[i] <= (i == 0 || i == 4 || i == 8) ?
                                              32'sd1073741824 : 32'sd0;
                            end
                        end else begin
                            r_jcnt <= w_frame[3:0];
                            for (int i = 0; i < 12; i++) begin
                                r_chain[i] <= r_nt[i];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    `DHFK_ASSERT(a_jcnt_below_max, ({1'b0, r_jcnt} < 5'(MAX_JOINTS)), "joint count overran")
    `DHFK_ASSERT(a_end_clears_count,
                 (r_state == ST_DONE && w_free && w_end) |=> (r_jcnt == 4'd0),
                 "chain end did not clear the joint count")
    `DHFK_ASSERT(a_pitch_zero_mid_chain,
                 (r_ovalid && !r_out.chain_end) |-> (r_out.pitch == 15'sd0),
                 "pitch nonzero on an open-chain result")

endmodule

FILE: tb/sv/dh_forward_kinematics_chain_checker.sv
// ----------------------------------------------------------------------------
// DH kinematics chain checker
// Watches the joint, frame and register channels, predicts every frame word
// from its own fixed-point model of the chain and compares it field by field.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [79:0]  i_s_tdata,
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,
    input  logic         i_m_tlast,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic         i_pready,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output int           o_fail_count,
    output int           o_frames_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      JOINT_LIMIT = 7;
    localparam int      CORDIC_STEPS = 30;
    localparam longint  UNIT = 64'sd1073741824;
    localparam longint  GAIN = 64'sd652032874;
    localparam longint  REACH_MAX = 64'sd262143;
    localparam longint  REACH_MIN = -64'sd262144;
    localparam longint  WORD_MAX = 64'sd2147483647;
    localparam longint  WORD_MIN = -64'sd2147483648;
    localparam logic [2:0] ADDR_THIRD_OFFSET = 3'd0;
    localparam logic [2:0] ADDR_FIFTH_OFFSET = 3'd4;

    localparam longint ARCTAN [CORDIC_STEPS] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

    typedef struct {
        longint frame_index;
        longint origin_x, origin_y, origin_z;
        longint shifted_x, shifted_y, shifted_z;
        longint pitch;
        longint chain_end;
    } frame_t;

    frame_t  frames_due[$];
    longint  pose[12];
    int      joints_done;
    longint  third_offset;
    longint  fifth_offset;

    assign o_frames_pending = frames_due.size();

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    // Rotation CORDIC on a binary angle after folding it into the half turn.
    function automatic void turn_to_cos_sin(input logic [31:0] ang, output longint c,
                                            output longint s);
        logic [31:0] probe;
        logic        flip;
        longint      x, y, z, dx, dy;
        probe = ang + 32'h40000000;
        flip = probe[31];
        if (flip) ang = ang + 32'h80000000;
        z = longint'($signed(ang));
        x = GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end else begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        x = clip(x, -UNIT, UNIT);
        y = clip(y, -UNIT, UNIT);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint pitch_centideg(input longint r00, input longint r10,
                                              input longint r20);
        longint x, y, z, dx, dy;
        x = floor_sqrt(longint'(r00 * r00) + longint'(r10 * r10));
        y = -r20;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARCTAN[i];
            end else begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
        end
        return clip((z * 36000 + 64'sd2147483648) >>> 32, -9000, 9000);
    endfunction

    function automatic void pose_identity();
        foreach (pose[i]) pose[i] = 0;
        pose[0] = UNIT;
        pose[4] = UNIT;
        pose[8] = UNIT;
    endfunction

    // Multiplies one joint transform onto the pose and returns its frame word.
    function automatic frame_t add_joint(input logic [79:0] data, input logic last);
        frame_t      f;
        longint      jang, toff, d, a, tw, ct, st, ca, sa, acc, off;
        longint      dh[9];
        longint      ex[3];
        longint      nxt[12];
        longint      o[3];
        longint      sh[3];
        logic [31:0] theta, alpha;
        jang = longint'($signed(data[15:0]));
        toff = longint'($signed(data[31:16]));
        d = longint'($signed(data[47:32]));
        a = longint'($signed(data[63:48]));
        tw = longint'($signed(data[79:64]));
        theta = 32'(jang * 119305) + 32'(toff * 83443);
        alpha = 32'(tw * 83443);
        turn_to_cos_sin(theta, ct, st);
        turn_to_cos_sin(alpha, ca, sa);
        dh = '{ct, -round_q30(st * ca), round_q30(st * sa),
               st, round_q30(ct * ca), -round_q30(ct * sa),
               0, sa, ca};
        ex = '{round_q30(a * ct), round_q30(a * st), d};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += pose[r*3+k] * dh[k*3+c];
                nxt[r*3+c] = clip(round_q30(acc), WORD_MIN, WORD_MAX);
            end
            acc = 0;
            for (int k = 0; k < 3; k++) acc += pose[r*3+k] * ex[k];
            nxt[9+r] = clip(pose[9+r] + round_q30(acc), REACH_MIN, REACH_MAX);
        end
        pose = nxt;
        f.frame_index = joints_done + 1;
        off = 0;
        if (f.frame_index == 3) off = third_offset;
        else if (f.frame_index == 5) off = fifth_offset;
        for (int r = 0; r < 3; r++) begin
            o[r] = nxt[9+r];
            sh[r] = clip(o[r] + round_q30(off * nxt[r*3+2]), REACH_MIN, REACH_MAX);
        end
        f.origin_x = o[0]; f.origin_y = o[1]; f.origin_z = o[2];
        f.shifted_x = sh[0]; f.shifted_y = sh[1]; f.shifted_z = sh[2];
        f.chain_end = (last || f.frame_index >= JOINT_LIMIT) ? 1 : 0;
        f.pitch = 0;
        if (f.chain_end != 0) begin
            f.pitch = pitch_centideg(nxt[0], nxt[3], nxt[6]);
            joints_done = 0;
            pose_identity();
        end else begin
            joints_done = int'(f.frame_index);
        end
        return f;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        frame_t f;
        if (!i_rst_n) begin
            third_offset = 768;
            fifth_offset = 2496;
            joints_done = 0;
            pose_identity();
            frames_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_THIRD_OFFSET) third_offset = i_pwdata[15:0];
                else if (i_paddr == ADDR_FIFTH_OFFSET) fifth_offset = i_pwdata[15:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                if (frames_due.size() == 0) begin
                    $error("frame word with none expected");
                    o_fail_count++;
                end else begin
                    f = frames_due.pop_front();
                    check_field("frame_index", f.frame_index, i_m_tdata[4:0]);
                    check_field("origin_x", f.origin_x, $signed(i_m_tdata[23:5]));
                    check_field("origin_y", f.origin_y, $signed(i_m_tdata[42:24]));
                    check_field("origin_z", f.origin_z, $signed(i_m_tdata[61:43]));
                    check_field("shifted_x", f.shifted_x, $signed(i_m_tdata[80:62]));
                    check_field("shifted_y", f.shifted_y, $signed(i_m_tdata[99:81]));
                    check_field("shifted_z", f.shifted_z, $signed(i_m_tdata[118:100]));
                    check_field("pitch", f.pitch, $signed(i_m_tdata[133:119]));
                    check_field("chain_end", f.chain_end, i_m_tlast);
                end
            end
            if (i_s_tvalid && i_s_tready) frames_due.push_back(add_joint(i_s_tdata, i_s_tlast));
        end
    end

endmodule

FILE: tb/sv/dh_forward_kinematics_chain_top_tb.sv
// ----------------------------------------------------------------------------
// DH kinematics chain testbench
// Drives joint words in bursts against a stalling frame receiver, walks the
// axis offset registers through several settings and reports the verdict.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_THIRD_OFFSET = 3'd0;
    localparam logic [2:0] ADDR_FIFTH_OFFSET = 3'd4;
    localparam int         IDLE_LIMIT = 20000;
    localparam int         HOLD_CYCLES = 3000;
    localparam int         SETTLE_CYCLES = 300;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int   fail_count;
    int   frames_pending;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;

    always #4 i_clk = ~i_clk;

    dh_forward_kinematics_chain_top dut (.*);

    dh_forward_kinematics_chain_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_frames_pending(frames_pending)
    );

    // Receiver: a random stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        hold_seen <= hold_toggle;
        if (hold_toggle != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("dh_forward_kinematics_chain_top verification failed");
            $finish;
        end
    end

    task automatic write_offset(input logic [2:0] addr, input logic [15:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= {16'($urandom_range(0, 65535)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (frames_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_joint(input logic [15:0] ang, input logic [15:0] toff,
                              input logic [15:0] d, input logic [15:0] a,
                              input logic [15:0] tw, input logic last, input bit gaps);
        if (gaps && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tdata <= {tw, a, d, toff, ang};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
    endtask

    function automatic logic [15:0] rand_angle();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 36000) - 18000);
    endfunction

    function automatic logic [15:0] rand_radians();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 51472) - 25736);
    endfunction

    task automatic random_chains(input int count, input bit gaps);
        int left, len;
        left = count;
        while (left > 0) begin
            len = $urandom_range(1, 9);
            for (int j = 0; j < len && left > 0; j++) begin
                send_joint(rand_angle(), rand_radians(),
                           ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 8000) - 4000),
                           ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 8000) - 4000),
                           rand_radians(),
                           (j == len - 1) ? ($urandom_range(0, 7) != 0)
                                          : ($urandom_range(0, 19) == 0),
                           gaps);
                left--;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_offset(ADDR_THIRD_OFFSET, 16'hFFFF);
        write_offset(ADDR_FIFTH_OFFSET, 16'h0000);

        // Directed: field extremes, a chain that overruns the joint limit
        // without a last marker, and a single-joint chain.
        send_joint(16'sd18000, 16'sd25736, 16'h7FFF, 16'h7FFF, 16'sd25736, 1'b0, 0);
        send_joint(-16'sd18000, -16'sd25736, 16'h8000, 16'h8000, -16'sd25736, 1'b0, 0);
        send_joint(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 0);
        send_joint(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 0);
        send_joint(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 0);
        send_joint(16'sd9000, 16'sd12868, 16'sd1600, 16'sd3200, 16'sd12868, 1'b0, 0);
        send_joint(-16'sd9000, 16'h0000, 16'sd800, -16'sd800, -16'sd12868, 1'b0, 0);
        send_joint(16'sd4500, 16'h0000, 16'sd100, 16'sd100, 16'h0000, 1'b0, 0);
        send_joint(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0);
        send_joint(16'sd9000, 16'h0000, 16'h0000, 16'sd1000, 16'sd12868, 1'b1, 0);
        send_joint(16'h0000, 16'h0000, 16'sd500, 16'sd500, -16'sd12868, 1'b0, 0);
        send_joint(16'sd18000, 16'h0000, -16'sd500, 16'sd500, 16'h0000, 1'b1, 0);
        drain();

        write_offset(ADDR_THIRD_OFFSET, 16'd0);
        write_offset(ADDR_FIFTH_OFFSET, 16'hFFFF);
        random_chains(300, 1);

        // Long receiver hold-off while joints keep coming, so the input stalls.
        hold_toggle <= ~hold_toggle;
        random_chains(40, 0);
        drain();

        write_offset(ADDR_THIRD_OFFSET, 16'd768);
        write_offset(ADDR_FIFTH_OFFSET, 16'd2496);
        random_chains(300, 1);
        drain();

        write_offset(ADDR_THIRD_OFFSET, 16'($urandom));
        write_offset(ADDR_FIFTH_OFFSET, 16'($urandom));
        random_chains(260, 1);
        drain();

        if (fail_count == 0) begin
            $display("dh_forward_kinematics_chain_top verification clean");
        end else begin
            $display("dh_forward_kinematics_chain_top verification failed");
        end
        $finish;
    end

endmodule
